// ===== rtl/core/binary_max_heap_queue_assert.svh =====
// Assertion macros for the heap queue: implication forms checked on clk.
// Included by the top level; expands to nothing when SYNTHESIS is set.
`ifndef BINARY_MAX_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define BMHQ_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("heap queue assertion failed");
`define BMHQ_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("heap queue assertion failed");
`else
`define BMHQ_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define BMHQ_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/core/bmhq_pkg.sv =====
// Shared types and codes for the binary max-heap priority queue.
// No dependencies; imported by bmhq_cmp and by the top level.
package bmhq_pkg;

  localparam int VALUE_W = 32;
  localparam int ENTRY_W = 11;

  // Request operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Result error codes
  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    err_t               err;
    logic [ENTRY_W-1:0] count;
    logic               is_empty;
    value_t             top;
  } result_t;

endpackage

// ===== rtl/core/bmhq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bmhq_cmp.sv =====
// Shared signed compare unit used by every sift step of the sequencer.
// Depends on bmhq_pkg for the value type.
module bmhq_cmp import bmhq_pkg::*; (
  input  value_t a,
  input  value_t b,
  output logic   gt
);

  // Signed greater-than
  assign gt = (a > b);

endmodule

// ===== rtl/core/binary_max_heap_queue.sv =====
// Binary max-heap priority queue: one RAM, one shared comparator, a sequencer.
// Insert climbs from the new leaf, with one parent read and compare per level; remove moves
// the last entry to the root and sinks it, reading the children of each level and comparing;
// errors and the last removal go straight to the result. A new request waits for the result.
// Reset (rst_n, synchronous, active low) empties the queue; RAM is not cleared.
// Depends on bmhq_pkg, bmhq_ram, bmhq_cmp and binary_max_heap_queue_assert.svh.
`include "binary_max_heap_queue_assert.svh"
module binary_max_heap_queue import bmhq_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [0:0]  in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] top_value, [42:32] entry_count, rest zero
  output logic [2:0]  out_tuser   // [0] is_empty, [2:1] error_code
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int CHW = AW + 2;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_UP_CHK  = 9'b000000010,
    ST_UP_CMP  = 9'b000000100,
    ST_DN_LAST = 9'b000001000,
    ST_DN_CHK  = 9'b000010000,
    ST_DN_RDL  = 9'b000100000,
    ST_DN_RDR  = 9'b001000000,
    ST_DN_CMP  = 9'b010000000,
    ST_FINISH  = 9'b100000000
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [AW-1:0]  cidx_r, cidx_nxt;
  value_t         key_r, key_nxt;
  value_t         cand_r, cand_nxt;
  value_t         top_r, top_nxt;
  err_t           err_r, err_nxt;
  logic           out_valid_r, out_valid_nxt;
  result_t        res_r, res_nxt;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  value_t         ram_wdata, ram_rdata;
  logic [VALUE_W-1:0] ram_rdata_raw;

  value_t         cmp_a, cmp_b;
  logic           cmp_gt;

  logic [AW-1:0]  parent_w;
  logic [CHW-1:0] left_w, right_w, cnt_ext;
  logic           left_ok, right_ok;
  logic [ENTRY_W+CW-1:0] cnt_wide;

  bmhq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = value_t'(ram_rdata_raw);

  bmhq_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .gt (cmp_gt)
  );

  // Tree neighbors of the current hole
  assign parent_w = AW'((idx_r - AW'(1)) >> 1);
  assign left_w   = {1'b0, idx_r, 1'b1};
  assign right_w  = left_w + CHW'(1);
  assign cnt_ext  = CHW'(count_r);
  assign left_ok  = (left_w < cnt_ext);
  assign right_ok = (right_w < cnt_ext);
  assign cnt_wide = {{ENTRY_W{1'b0}}, count_r};

  // Steer the shared comparator
  always_comb begin
    case (state_r)
      ST_UP_CMP: begin
        cmp_a = key_r;
        cmp_b = ram_rdata;
      end
      ST_DN_RDR: begin
        cmp_a = ram_rdata;
        cmp_b = cand_r;
      end
      default: begin
        cmp_a = cand_r;
        cmp_b = key_r;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cidx_nxt      = cidx_r;
    key_nxt       = key_r;
    cand_nxt      = cand_r;
    err_nxt       = err_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    in_tready     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = key_r;
    ram_re        = 1'b0;
    ram_raddr     = parent_w;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          err_nxt = ERR_OK;
          if (in_tuser[0] == FUNC_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              err_nxt   = ERR_FULL;
              state_nxt = ST_FINISH;
            end else begin
              key_nxt   = value_t'(in_tdata);
              idx_nxt   = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
              state_nxt = ST_UP_CHK;
            end
          end else begin
            if (count_r == '0) begin
              err_nxt   = ERR_EMPTY;
              state_nxt = ST_FINISH;
            end else begin
              count_nxt = count_r - CW'(1);
              if (count_r == CW'(1)) begin
                state_nxt = ST_FINISH;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(count_r - CW'(1));
                state_nxt = ST_DN_LAST;
              end
            end
          end
        end
      end
      ST_UP_CHK: begin
        if (idx_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          ram_re    = 1'b1;
          state_nxt = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        ram_we = 1'b1;
        if (cmp_gt) begin
          // move the smaller parent down into the hole, climb
          ram_wdata = ram_rdata;
          idx_nxt   = parent_w;
          state_nxt = ST_UP_CHK;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_DN_LAST: begin
        key_nxt   = ram_rdata;
        idx_nxt   = '0;
        state_nxt = ST_DN_CHK;
      end
      ST_DN_CHK: begin
        if (!left_ok) begin
          ram_we    = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = left_w[AW-1:0];
          state_nxt = ST_DN_RDL;
        end
      end
      ST_DN_RDL: begin
        cand_nxt = ram_rdata;
        cidx_nxt = left_w[AW-1:0];
        if (right_ok) begin
          ram_re    = 1'b1;
          ram_raddr = right_w[AW-1:0];
          state_nxt = ST_DN_RDR;
        end else begin
          state_nxt = ST_DN_CMP;
        end
      end
      ST_DN_RDR: begin
        // take the right child only when strictly larger
        if (cmp_gt) begin
          cand_nxt = ram_rdata;
          cidx_nxt = right_w[AW-1:0];
        end
        state_nxt = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        ram_we = 1'b1;
        if (cmp_gt) begin
          ram_wdata = cand_r;
          idx_nxt   = cidx_r;
          state_nxt = ST_DN_CHK;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          res_nxt.err      = err_r;
          res_nxt.count    = cnt_wide[ENTRY_W-1:0];
          res_nxt.is_empty = (count_r == '0);
          res_nxt.top      = (count_r == '0) ? value_t'(0) : top_r;
          out_valid_nxt    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Track the root value as it is written
  always_comb begin
    top_nxt = top_r;
    if (ram_we && (ram_waddr == '0)) begin
      top_nxt = ram_wdata;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    cidx_r <= cidx_nxt;
    key_r  <= key_nxt;
    cand_r <= cand_nxt;
    top_r  <= top_nxt;
    err_r  <= err_nxt;
    res_r  <= res_nxt;
  end

  // Pack the result
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.count, res_r.top};
  assign out_tuser  = {res_r.err, res_r.is_empty};

  // Checks
  `BMHQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY))
  `BMHQ_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `BMHQ_ASSERT_IMP(a_write_in_heap, clk, rst_n, ram_we, CW'(ram_waddr) < count_r)
  `BMHQ_ASSERT_IMP(a_empty_top_zero, clk, rst_n, out_tvalid && out_tuser[0],
                   out_tdata[31:0] == 32'd0)

endmodule
